// ----- design/psp_pkg.sv -----
// Package for the polyphonic sample player: item kinds, payload structs and
// the queue entry passed from the front to the back. No dependencies.
package psp_pkg;

  localparam logic [2:0] KIND_WRITE   = 3'd0;
  localparam logic [2:0] KIND_SLOT    = 3'd1;
  localparam logic [2:0] KIND_TRIGGER = 3'd2;
  localparam logic [2:0] KIND_STOP    = 3'd3;
  localparam logic [2:0] KIND_STOPALL = 3'd4;
  localparam logic [2:0] KIND_TICK    = 3'd5;

  localparam int SAMPLE_WORDS = 65536;

  localparam logic signed [18:0] MIX_MAX = 19'sd262143;
  localparam logic signed [18:0] MIX_MIN = -19'sd262144;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [3:0]         slot;
    logic [16:0]        slot_length;
    logic               slot_loaded;
    logic [7:0]         velocity;
    logic [23:0]        speed;
    logic               loop_enable;
    logic [2:0]         voice;
  } in_item_t;

  typedef struct packed {
    logic signed [18:0] mix;
    logic [2:0]         voice_index;
    logic               trigger_ok;
    logic [3:0]         active_voices;
  } out_item_t;

endpackage

// ----- design/psp_front.sv -----
// Front part of the sample player: accepts requests and holds them in a
// short queue for the back part. Depends on psp_pkg.
module psp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psp_pkg::in_item_t  push_item,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output psp_pkg::in_item_t  head
);
  import psp_pkg::*;

  in_item_t  q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rp_r];
endmodule

// ----- design/psp_back.sv -----
// Back part of the sample player: executes requests, owns the sample memory,
// slot table and voice state, and walks the voices one at a time on a tick.
// Depends on psp_pkg.
module psp_back #(
  parameter int VOICES = 8,
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               have,
  input  psp_pkg::in_item_t  item,
  output logic               pop,
  output logic               idle,
  output logic               out_strobe,
  output psp_pkg::out_item_t out_item
);
  import psp_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int CW = $clog2(VOICES + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TRIG  = 9'b000000010,
    S_VSET  = 9'b000000100,
    S_RD0   = 9'b000001000,
    S_RD1   = 9'b000010000,
    S_MUL1  = 9'b000100000,
    S_MUL2  = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_DONE  = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;

  logic signed [15:0] mem [SAMPLE_WORDS];
  logic signed [15:0] rd_r;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;

  logic [15:0] sbase_r [SLOTS];
  logic [16:0] ssize_r [SLOTS];
  logic [SLOTS-1:0] svalid_r;

  logic [VOICES-1:0] act_r;
  logic [3:0]  vslot_r [VOICES];
  logic [32:0] vpos_r  [VOICES];
  logic [23:0] vspd_r  [VOICES];
  logic [7:0]  vgain_r [VOICES];
  logic [VOICES-1:0] vloop_r;

  in_item_t   it_r;
  logic [VW-1:0] vi_r, best_r;
  logic [32:0] bestp_r;
  logic        found_r;
  logic        vlast_r;
  logic signed [21:0] acc_r;
  logic signed [15:0] s0_r;
  logic [32:0] pos_r;
  logic [16:0] idx_r, len_r;
  logic [15:0] base_r;
  logic signed [33:0] p1_r;
  logic signed [25:0] p2_r;

  logic [SW-1:0] vs;
  logic [16:0]   len_v, idx_v;
  logic [32:0]   pos_v;
  logic          live_v;
  logic          wrap_v;
  logic          play_v;
  logic signed [33:0] p1_abs;
  logic signed [17:0] q1;
  logic signed [16:0] interp;
  logic signed [25:0] p2_abs;
  logic [CW-1:0] cnt;
  logic signed [21:0] acc_sat_in;
  logic signed [18:0] mix_sat;

  always_comb begin
    vs     = SW'(vslot_r[vi_r]);
    len_v  = ssize_r[vs];
    pos_v  = vpos_r[vi_r];
    live_v = act_r[vi_r];
    idx_v  = pos_v[32:16];
    wrap_v = (idx_v >= len_v);
    play_v = live_v && !(wrap_v && !(vloop_r[vi_r] && len_v != 17'd0));
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
    else if (st_r == S_IDLE && have && item.kind == KIND_WRITE)
      mem[item.address[AW-1:0]] <= item.sample_value;
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (st_r == S_VSET) begin
      rd_en = 1'b1;
      rd_addr = AW'(32'(sbase_r[vs]) + 32'(wrap_v ? 17'd0 : idx_v));
    end else if (st_r == S_RD0) begin
      rd_en = 1'b1;
      rd_addr = AW'(32'(base_r) + 32'(idx_r) + 32'd1);
    end
  end

  always_comb begin
    p1_abs = (p1_r < 0) ? -p1_r : p1_r;
    q1     = 18'(p1_abs >>> 16);
    interp = 17'(s0_r) + ((p1_r < 0) ? -17'(q1) : 17'(q1));
    p2_abs = (p2_r < 0) ? -p2_r : p2_r;
    cnt = '0;
    for (int i = 0; i < VOICES; i++) cnt = cnt + CW'(act_r[i]);
    acc_sat_in = acc_r;
    if (acc_sat_in > 22'(MIX_MAX)) mix_sat = MIX_MAX;
    else if (acc_sat_in < 22'(MIX_MIN)) mix_sat = MIX_MIN;
    else mix_sat = 19'(acc_sat_in);
  end

  // Division by 255: the reciprocal estimate is at most one low, so one
  // compare and increment gives the exact quotient.
  logic signed [25:0] div255;
  logic [25:0] pmag;
  logic [25:0] qq;
  always_comb begin
    pmag = 26'(p2_abs);
    qq = 26'((52'(pmag) * 52'd263172) >> 26);
    if (pmag - qq * 26'd255 >= 26'd255) qq = qq + 26'd1;
    div255 = (p2_r < 0) ? -$signed(qq) : $signed(qq);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (have) begin
        priority case (item.kind)
          KIND_TRIGGER: st_nxt = (32'(item.slot) < SLOTS && svalid_r[SW'(item.slot)])
                                 ? S_TRIG : S_DONE;
          KIND_TICK:    st_nxt = S_VSET;
          default:      st_nxt = S_DONE;
        endcase
      end
      S_TRIG: if (vlast_r || !act_r[vi_r]) st_nxt = S_DONE;
      S_VSET: st_nxt = play_v ? S_RD0 : (vlast_r ? S_DONE : S_VSET);
      S_RD0:  st_nxt = S_RD1;
      S_RD1:  st_nxt = S_MUL1;
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_ACC;
      S_ACC:  st_nxt = vlast_r ? S_DONE : S_VSET;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign pop  = (st_r == S_IDLE) && have;
  assign idle = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      svalid_r <= '0;
      act_r <= '0;
      vloop_r <= '0;
      out_strobe <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        sbase_r[i] <= '0; ssize_r[i] <= '0;
      end
      for (int i = 0; i < VOICES; i++) begin
        vslot_r[i] <= '0; vpos_r[i] <= '0; vspd_r[i] <= '0; vgain_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      out_strobe <= (st_r == S_DONE);
      unique case (st_r)
        S_IDLE: if (have) begin
          it_r <= item;
          vi_r <= '0;
          vlast_r <= (VOICES == 1);
          acc_r <= '0;
          found_r <= 1'b0;
          bestp_r <= '0;
          best_r <= '0;
          if (item.kind == KIND_SLOT && 32'(item.slot) < SLOTS) begin
            sbase_r[SW'(item.slot)]  <= item.address;
            ssize_r[SW'(item.slot)]  <= item.slot_length;
            svalid_r[SW'(item.slot)] <= item.slot_loaded;
          end
          if (item.kind == KIND_STOP && 32'(item.voice) < VOICES)
            act_r[VW'(item.voice)] <= 1'b0;
          if (item.kind == KIND_STOPALL) act_r <= '0;
        end
        S_TRIG: begin
          if (vlast_r || !act_r[vi_r]) begin
            logic [VW-1:0] v;
            v = !act_r[vi_r] ? vi_r
              : ((vi_r == '0 || vpos_r[vi_r] > bestp_r) ? vi_r : best_r);
            vslot_r[v] <= it_r.slot; vpos_r[v] <= '0; vspd_r[v] <= it_r.speed;
            vgain_r[v] <= it_r.velocity; act_r[v] <= 1'b1;
            vloop_r[v] <= it_r.loop_enable;
            best_r <= v; found_r <= 1'b1;
          end else begin
            if (vi_r == '0 || vpos_r[vi_r] > bestp_r) begin
              bestp_r <= vpos_r[vi_r];
              best_r <= vi_r;
            end
            vi_r <= vi_r + VW'(1);
            vlast_r <= (32'(vi_r) + 2 == VOICES);
          end
        end
        S_VSET: begin
          base_r <= sbase_r[vs];
          len_r <= len_v;
          pos_r <= wrap_v ? 33'd0 : pos_v;
          idx_r <= wrap_v ? 17'd0 : idx_v;
          if (live_v && !play_v)
            act_r[vi_r] <= 1'b0;
          if (!play_v) begin
            vi_r <= vi_r + VW'(1);
            vlast_r <= (32'(vi_r) + 2 == VOICES);
          end
        end
        S_RD0: s0_r <= rd_r;
        S_RD1: begin
          logic signed [16:0] d;
          // The second sample word is replaced by the first past the end.
          d = 17'((idx_r + 17'd1 < len_r) ? rd_r : s0_r) - 17'(s0_r);
          p1_r <= 34'($signed({1'b0, pos_r[15:0]})) * 34'(d);
        end
        S_MUL1: p2_r <= 26'(interp) * $signed({18'd0, vgain_r[vi_r]});
        S_MUL2: p2_r <= div255;
        S_ACC: begin
          acc_r <= acc_r + 22'(p2_r);
          vpos_r[vi_r] <= pos_r + 33'(vspd_r[vi_r]);
          vi_r <= vi_r + VW'(1);
          vlast_r <= (32'(vi_r) + 2 == VOICES);
        end
        S_DONE: begin
          out_item.mix <= (it_r.kind == KIND_TICK) ? mix_sat : '0;
          out_item.voice_index <= (it_r.kind == KIND_TRIGGER && found_r) ?
                                  3'(best_r) : 3'd0;
          out_item.trigger_ok <= (it_r.kind == KIND_TRIGGER) && found_r;
          out_item.active_voices <= 4'(cnt);
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- design/polyphonic_sample_player_unit.sv -----
// Top level of the polyphonic sample player: command front, request queue
// and voice engine. Depends on psp_pkg, psp_front and psp_back.
//
//  channel  | handshake             | payload
//  in_      | start, busy           | in_item (in_item_t)
//  out_     | out_strobe            | out_item (out_item_t)
//
// A simple request passes through the engine's done state; a trigger also
// scans the voices for a free one, and a tick visits every voice, reading
// two sample words in turn through the single read port of the sample
// memory for each voice that plays. Reset is synchronous and clears the
// slot table and voice state; sample memory is unset until written.
// The receiver cannot stall; busy rises only when the two-entry request queue
// is full.
module polyphonic_sample_player_unit #(
  parameter int VOICES = 8,
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  psp_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output psp_pkg::out_item_t out_item
);
  import psp_pkg::*;

  logic     full, have, pop, idle;
  in_item_t head;

  psp_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_item(in_item),
    .pop(pop), .full(full), .not_empty(have), .head(head)
  );

  psp_back #(.VOICES(VOICES), .SLOTS(SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .have(have), .item(head), .pop(pop), .idle(idle),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  assign busy = full;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> idle && have) else $error("pop while engine busy");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.active_voices <= 4'(VOICES))
    else $error("active count exceeds voices");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("back-to-back results");
endmodule
